// ===== src/jsu_pkg.sv =====
// Shared types and constants for the JSON string unescaper.
// No dependencies; every other file refers to it by scoped names.
package jsu_pkg;

   localparam int JOB_BYTES = 6;   // most data bytes one input byte can expand to
   localparam int COUNT_W = $clog2(JOB_BYTES + 1);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [15:0] CAP_RESET = 16'd4096;

   localparam logic [7:0] CHR_NUL = 8'h00;
   localparam logic [7:0] CHR_QUOTE = 8'h22;
   localparam logic [7:0] CHR_SLASH = 8'h2F;
   localparam logic [7:0] CHR_BSLASH = 8'h5C;
   localparam logic [7:0] CHR_B = 8'h62;
   localparam logic [7:0] CHR_F = 8'h66;
   localparam logic [7:0] CHR_N = 8'h6E;
   localparam logic [7:0] CHR_R = 8'h72;
   localparam logic [7:0] CHR_T = 8'h74;
   localparam logic [7:0] CHR_U = 8'h75;
   localparam logic [7:0] CHR_BS = 8'h08;
   localparam logic [7:0] CHR_FF = 8'h0C;
   localparam logic [7:0] CHR_LF = 8'h0A;
   localparam logic [7:0] CHR_CR = 8'h0D;
   localparam logic [7:0] CHR_TAB = 8'h09;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_string;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        byte_valid;
      logic        run_last;
      logic        string_done;
      logic [15:0] out_length;
      logic        overflow;
   } rsp_type;

   // Work for the back end: candidate data bytes, then an end marker if done.
   typedef struct packed {
      logic [JOB_BYTES-1:0][7:0] data;
      logic [COUNT_W-1:0]        count;
      logic                      done;
   } job_type;

endpackage

// ===== src/jsu_front.sv =====
// Front end: escape decoder. Turns each accepted byte into a job of candidate bytes.
// Depends on jsu_pkg.
module jsu_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  jsu_pkg::req_type in_data,
   output logic             job_valid,
   output jsu_pkg::job_type job
);

   typedef enum logic [2:0] {
      MODE_NORMAL = 3'b001,
      MODE_ESC    = 3'b010,
      MODE_HEX    = 3'b100
   } mode_type;

   mode_type        mode_ff, mode_in;
   logic [11:0]     hv_ff, hv_in;
   logic [1:0]      hc_ff, hc_in;
   logic            term_ff, term_in;
   logic [2:0][7:0] held_ff, held_in;

   function automatic jsu_pkg::job_type job_put(jsu_pkg::job_type j, logic [7:0] b);
      j.data[j.count[2:0]] = b;
      j.count = j.count + jsu_pkg::COUNT_W'(1);
      return j;
   endfunction

   // {ok, nibble}; letters in either case have low nibble 1..6
   function automatic logic [4:0] hex_of(logic [7:0] b);
      logic [4:0] r;
      r = 5'd0;
      if (b >= 8'h30 && b <= 8'h39) r = {1'b1, b[3:0]};
      else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
         r = {1'b1, b[3:0] + 4'd9};
      return r;
   endfunction

   always_comb begin
      jsu_pkg::job_type j;
      logic [7:0]  b;
      logic [4:0]  hx;
      logic [15:0] code;
      logic        do_plain;
      logic        do_flush;
      j = '0;
      b = in_data.in_byte;
      hx = hex_of(b);
      code = {hv_ff, hx[3:0]};
      do_plain = 1'b0;
      do_flush = 1'b0;
      mode_in = mode_ff;
      hv_in = hv_ff;
      hc_in = hc_ff;
      term_in = term_ff;
      held_in = held_ff;

      if (!term_ff) begin
         case (mode_ff)
            MODE_ESC: begin
               mode_in = MODE_NORMAL;
               case (b)
                  jsu_pkg::CHR_QUOTE, jsu_pkg::CHR_BSLASH, jsu_pkg::CHR_SLASH: j = job_put(j, b);
                  jsu_pkg::CHR_B: j = job_put(j, jsu_pkg::CHR_BS);
                  jsu_pkg::CHR_F: j = job_put(j, jsu_pkg::CHR_FF);
                  jsu_pkg::CHR_N: j = job_put(j, jsu_pkg::CHR_LF);
                  jsu_pkg::CHR_R: j = job_put(j, jsu_pkg::CHR_CR);
                  jsu_pkg::CHR_T: j = job_put(j, jsu_pkg::CHR_TAB);
                  jsu_pkg::CHR_U: begin
                     mode_in = MODE_HEX;
                     hc_in = 2'd0;
                     hv_in = 12'd0;
                  end
                  default: begin
                     j = job_put(j, jsu_pkg::CHR_BSLASH);
                     do_plain = 1'b1;
                  end
               endcase
            end
            MODE_HEX: begin
               if (hx[4]) begin
                  if (hc_ff == 2'd3) begin
                     if (code <= 16'h007F) begin
                        j = job_put(j, code[7:0]);
                     end else if (code <= 16'h07FF) begin
                        j = job_put(j, {3'b110, code[10:6]});
                        j = job_put(j, {2'b10, code[5:0]});
                     end else begin
                        j = job_put(j, {4'b1110, code[15:12]});
                        j = job_put(j, {2'b10, code[11:6]});
                        j = job_put(j, {2'b10, code[5:0]});
                     end
                     mode_in = MODE_NORMAL;
                     hc_in = 2'd0;
                     hv_in = 12'd0;
                  end else begin
                     held_in[hc_ff] = b;
                     hv_in = {hv_ff[7:0], hx[3:0]};
                     hc_in = hc_ff + 2'd1;
                  end
               end else begin
                  do_flush = 1'b1;
                  do_plain = 1'b1;
               end
            end
            default: begin
               mode_in = MODE_NORMAL;
               do_plain = 1'b1;
            end
         endcase
      end

      // cut-short \u at end of string is flushed the same way as a bad digit
      if (in_data.end_of_string && mode_in == MODE_HEX) do_flush = 1'b1;

      if (do_flush) begin
         j = job_put(j, jsu_pkg::CHR_BSLASH);
         j = job_put(j, jsu_pkg::CHR_U);
         for (int i = 0; i < 3; i++) begin
            if (2'(i) < hc_in) j = job_put(j, held_in[i]);
         end
         mode_in = MODE_NORMAL;
         hc_in = 2'd0;
         hv_in = 12'd0;
      end

      if (do_plain) begin
         if (b == jsu_pkg::CHR_NUL) term_in = 1'b1;
         else if (b == jsu_pkg::CHR_BSLASH) mode_in = MODE_ESC;
         else j = job_put(j, b);
      end

      if (in_data.end_of_string) begin
         j.done = 1'b1;
         mode_in = MODE_NORMAL;
         hc_in = 2'd0;
         hv_in = 12'd0;
         term_in = 1'b0;
      end

      job = j;
      job_valid = accept && (j.done || j.count != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NORMAL;
         hv_ff <= 12'd0;
         hc_ff <= 2'd0;
         term_ff <= 1'b0;
      end else if (accept) begin
         mode_ff <= mode_in;
         hv_ff <= hv_in;
         hc_ff <= hc_in;
         term_ff <= term_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) held_ff <= held_in;
   end

`ifndef SYNTH
   a_digits_only_in_hex: assert property (@(posedge clock) disable iff (reset)
      hc_ff != 2'd0 |-> mode_ff == MODE_HEX)
      else $error("hex digits held outside \\u mode");
`endif

endmodule

// ===== src/jsu_queue.sv =====
// Short job queue between the front and back ends.
// Depends on jsu_pkg.
module jsu_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  jsu_pkg::job_type wdata,
   output logic             full,
   input  logic             pop,
   output jsu_pkg::job_type rdata,
   output logic             empty
);

   jsu_pkg::job_type [jsu_pkg::QUEUE_DEPTH-1:0] slot_ff;
   logic [jsu_pkg::QPTR_W-1:0] wr_ff, rd_ff;
   logic [jsu_pkg::QCNT_W-1:0] cnt_ff;

   assign full = cnt_ff == jsu_pkg::QCNT_W'(jsu_pkg::QUEUE_DEPTH);
   assign empty = cnt_ff == '0;
   assign rdata = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + jsu_pkg::QPTR_W'(1);
         if (pop) rd_ff <= rd_ff + jsu_pkg::QPTR_W'(1);
         if (push && !pop) cnt_ff <= cnt_ff + jsu_pkg::QCNT_W'(1);
         else if (pop && !push) cnt_ff <= cnt_ff - jsu_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= wdata;
   end

`ifndef SYNTH
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push && full) && !(pop && empty))
      else $error("job queue overrun or underrun");
`endif

endmodule

// ===== src/jsu_back.sv =====
// Back end: walks each job a byte per cycle when its result slot is free,
// applies the capacity limit, keeps per-string lengths. Depends on jsu_pkg.
module jsu_back (
   input  logic             clock,
   input  logic             reset,
   input  logic [15:0]      capacity,
   input  logic             job_empty,
   input  jsu_pkg::job_type job,
   output logic             job_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output jsu_pkg::rsp_type rsp_data
);

   logic [jsu_pkg::COUNT_W-1:0] idx_ff, idx_in;
   logic [15:0]      kept_ff, kept_in;
   logic             ovf_ff, ovf_in;
   logic             out_valid_ff, out_valid_in;
   jsu_pkg::rsp_type rsp_ff, rsp_in;

   logic        slot_free, step, has_byte, keep, marker, at_last, job_end, produce;
   logic [7:0]  sel_byte;
   logic [15:0] kept_inc;

   assign slot_free = !out_valid_ff || rsp_pop;
   assign step = !job_empty && slot_free;
   assign has_byte = idx_ff < job.count;
   assign keep = has_byte && kept_ff < capacity;
   assign marker = !has_byte;
   assign at_last = idx_ff == job.count - jsu_pkg::COUNT_W'(1);
   assign job_end = marker || (has_byte && !job.done && at_last);
   assign produce = keep || marker;
   assign kept_inc = kept_ff + 16'd1;
   assign job_pop = step && job_end;

   always_comb begin
      sel_byte = 8'd0;
      for (int i = 0; i < jsu_pkg::JOB_BYTES; i++) begin
         if (idx_ff == jsu_pkg::COUNT_W'(i)) sel_byte = job.data[i];
      end
   end

   always_comb begin
      idx_in = idx_ff;
      kept_in = kept_ff;
      ovf_in = ovf_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      rsp_in = rsp_ff;
      if (step) begin
         idx_in = job_end ? '0 : idx_ff + jsu_pkg::COUNT_W'(1);
         out_valid_in = produce;
         if (marker) begin
            rsp_in = '{out_byte: 8'd0, byte_valid: 1'b0, run_last: 1'b1,
                       string_done: 1'b1, out_length: kept_ff, overflow: ovf_ff};
            kept_in = 16'd0;
            ovf_in = 1'b0;
         end else if (keep) begin
            // later bytes of the same job are dropped once capacity is hit
            rsp_in = '{out_byte: sel_byte, byte_valid: 1'b1,
                       run_last: !job.done && (at_last || kept_inc == capacity),
                       string_done: 1'b0, out_length: kept_inc, overflow: ovf_ff};
            kept_in = kept_inc;
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         kept_ff <= 16'd0;
         ovf_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         kept_ff <= kept_in;
         ovf_ff <= ovf_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data = rsp_ff;

`ifndef SYNTH
   a_idx_in_job: assert property (@(posedge clock) disable iff (reset)
      !job_empty |-> idx_ff <= job.count)
      else $error("byte index past end of job");
   a_marker_clears: assert property (@(posedge clock) disable iff (reset)
      step && marker |=> kept_ff == 16'd0 && !ovf_ff)
      else $error("string state not cleared after end marker");
   a_done_shape: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_ff.string_done |-> !rsp_ff.byte_valid && rsp_ff.run_last)
      else $error("malformed end marker transaction");
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_pop |=> out_valid_ff && $stable(rsp_ff))
      else $error("waiting result changed");
`endif

endmodule

// ===== src/json_string_unescape_top.sv =====
// JSON string body unescaper, top level.
// Depends on jsu_pkg, jsu_front, jsu_queue, jsu_back.
//
// Feed the escaped string body one byte per transaction; mark the last byte
// with end_of_string. Results come out in order as data bytes and one end
// marker per string carrying the kept length and the overflow flag. The front
// decoder takes one byte every cycle while its four-entry job queue has room;
// the back end takes one step per candidate output byte (kept or dropped
// beyond capacity) plus one for each end marker, and holds while its result
// waits. Each result passes through the job queue and the result register.
// output_capacity is to be written through csr_we/csr_wdata only while no
// transaction is in flight; the block itself does not enforce it.
module json_string_unescape_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  jsu_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output jsu_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [15:0]      csr_wdata
);

   logic [15:0]      capacity_ff;
   logic             accept, job_valid, q_full, q_empty, q_pop;
   jsu_pkg::job_type job_w, job_r;

   always_ff @(posedge clock) begin
      if (reset) capacity_ff <= jsu_pkg::CAP_RESET;
      else if (csr_we) capacity_ff <= csr_wdata;
   end

   assign req_full = q_full;
   assign accept = req_push && !q_full;

   jsu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .in_data   (req_data),
      .job_valid (job_valid),
      .job       (job_w)
   );

   jsu_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (job_valid),
      .wdata (job_w),
      .full  (q_full),
      .pop   (q_pop),
      .rdata (job_r),
      .empty (q_empty)
   );

   jsu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .capacity  (capacity_ff),
      .job_empty (q_empty),
      .job       (job_r),
      .job_pop   (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== sim/json_string_unescape_top_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for json_string_unescape_top: escaped bytes in, unescaped bytes out.
// Needs jsu_pkg and the RTL under src; holds its own unescaper to predict every result.
module json_string_unescape_top_tb;

   localparam int HEX_DIGITS = 4;
   localparam int SETTLE_CYCLES = 64;
   localparam int QUIET_LIMIT = 2000;
   localparam int PHASE_ITEMS = 50;

   typedef enum logic [2:0] {
      ESC_NONE      = 3'b001,
      ESC_BACKSLASH = 3'b010,
      ESC_HEX       = 3'b100
   } esc_state_type;

   // {end_of_string, byte}
   localparam logic [8:0] DIRECTED [24] = '{
      // bad digit after three held digits, which also ends the string: seven results
      {1'b0, jsu_pkg::CHR_BSLASH}, {1'b0, jsu_pkg::CHR_U}, {1'b0, 8'h61}, {1'b0, 8'h42},
      {1'b0, 8'h63},
      {1'b1, 8'h5A},
      // unknown escape, then a \u cut short by the end of the string
      {1'b0, jsu_pkg::CHR_BSLASH}, {1'b0, 8'h71}, {1'b0, jsu_pkg::CHR_BSLASH},
      {1'b0, jsu_pkg::CHR_U}, {1'b1, 8'h37},
      // lone trailing backslash
      {1'b1, jsu_pkg::CHR_BSLASH},
      // backslash then zero: backslash kept, string stops, later byte silent
      {1'b0, jsu_pkg::CHR_BSLASH}, {1'b0, jsu_pkg::CHR_NUL}, {1'b1, 8'h79},
      // \u0000 gives a data byte of zero
      {1'b0, jsu_pkg::CHR_BSLASH}, {1'b0, jsu_pkg::CHR_U}, {1'b0, 8'h30}, {1'b0, 8'h30},
      {1'b0, 8'h30},
      {1'b1, 8'h30},
      {1'b0, jsu_pkg::CHR_BSLASH}, {1'b0, jsu_pkg::CHR_N}, {1'b1, 8'hFF}
   };

   localparam logic [7:0] SIMPLE_ESC [8] = '{jsu_pkg::CHR_QUOTE, jsu_pkg::CHR_BSLASH,
                                              jsu_pkg::CHR_SLASH, jsu_pkg::CHR_B,
                                              jsu_pkg::CHR_F, jsu_pkg::CHR_N,
                                              jsu_pkg::CHR_R, jsu_pkg::CHR_T};
   localparam logic [15:0] CAP_STEPS [6] = '{16'd1, 16'hFFFF, 16'd6, 16'h8000, 16'd2,
                                              jsu_pkg::CAP_RESET};
   localparam logic [15:0] CODE_EDGES [6] = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF,
                                               16'h0800, 16'hFFFF};

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_push = 1'b0;
   logic             req_full;
   jsu_pkg::req_type req_data = '0;
   logic             rsp_empty;
   logic             rsp_pop = 1'b0;
   jsu_pkg::rsp_type rsp_data;
   logic             csr_we = 1'b0;
   logic [15:0]      csr_wdata = '0;

   json_string_unescape_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   jsu_pkg::req_type pending_in [$];
   jsu_pkg::rsp_type awaited_out [$];
   bit      steady = 1'b0;   // no idling on either side while set

   int n_items = 0;
   int n_results = 0;
   int n_strings = 0;
   int n_overflowed = 0;
   int n_errors = 0;

   // Unescaper copy, updated as each transaction is accepted
   logic [15:0]      capacity = jsu_pkg::CAP_RESET;
   esc_state_type    esc_mode = ESC_NONE;
   logic [15:0]      hex_acc = '0;
   int               hex_n = 0;
   logic [7:0]       digit_hold [3] = '{8'h00, 8'h00, 8'h00};
   logic [15:0]      kept = '0;
   bit               dropped = 1'b0;
   bit               stopped = 1'b0;
   jsu_pkg::rsp_type step_out [$];

   task automatic keep_byte(input logic [7:0] b);
      jsu_pkg::rsp_type r;
      if (kept < capacity) begin
         kept = kept + 16'd1;
         r = '0;
         r.out_byte = b;
         r.byte_valid = 1'b1;
         r.out_length = kept;
         r.overflow = dropped;
         step_out.push_back(r);
      end else begin
         dropped = 1'b1;
      end
   endtask

   task automatic plain_char(input logic [7:0] b);
      if (stopped) return;
      if (b == jsu_pkg::CHR_NUL) stopped = 1'b1;
      else if (b == jsu_pkg::CHR_BSLASH) esc_mode = ESC_BACKSLASH;
      else keep_byte(b);
   endtask

   // pass \u and the held digits through as they came
   task automatic flush_hex();
      keep_byte(jsu_pkg::CHR_BSLASH);
      keep_byte(jsu_pkg::CHR_U);
      for (int i = 0; i < hex_n; i++) keep_byte(digit_hold[i]);
      esc_mode = ESC_NONE;
      hex_n = 0;
      hex_acc = '0;
   endtask

   task automatic unescape_byte(input jsu_pkg::req_type it);
      logic [7:0]       b;
      logic [15:0]      code;
      int               nib;
      int               last;
      jsu_pkg::rsp_type r;
      b = it.in_byte;
      step_out.delete();
      if (!stopped) begin
         case (esc_mode)
            ESC_BACKSLASH: begin
               esc_mode = ESC_NONE;
               case (b)
                  jsu_pkg::CHR_QUOTE, jsu_pkg::CHR_BSLASH, jsu_pkg::CHR_SLASH: keep_byte(b);
                  jsu_pkg::CHR_B: keep_byte(jsu_pkg::CHR_BS);
                  jsu_pkg::CHR_F: keep_byte(jsu_pkg::CHR_FF);
                  jsu_pkg::CHR_N: keep_byte(jsu_pkg::CHR_LF);
                  jsu_pkg::CHR_R: keep_byte(jsu_pkg::CHR_CR);
                  jsu_pkg::CHR_T: keep_byte(jsu_pkg::CHR_TAB);
                  jsu_pkg::CHR_U: begin
                     esc_mode = ESC_HEX;
                     hex_n = 0;
                     hex_acc = '0;
                  end
                  default: begin
                     keep_byte(jsu_pkg::CHR_BSLASH);
                     plain_char(b);
                  end
               endcase
            end
            ESC_HEX: begin
               nib = -1;
               if (b >= 8'h30 && b <= 8'h39) nib = int'(b) - 'h30;
               else if (b >= 8'h61 && b <= 8'h66) nib = int'(b) - 'h61 + 10;
               else if (b >= 8'h41 && b <= 8'h46) nib = int'(b) - 'h41 + 10;
               if (nib < 0) begin
                  flush_hex();
                  plain_char(b);
               end else if (hex_n >= HEX_DIGITS - 1) begin
                  code = {hex_acc[11:0], nib[3:0]};
                  if (code <= 16'h007F) begin
                     keep_byte(code[7:0]);
                  end else if (code <= 16'h07FF) begin
                     keep_byte({3'b110, code[10:6]});
                     keep_byte({2'b10, code[5:0]});
                  end else begin
                     keep_byte({4'b1110, code[15:12]});
                     keep_byte({2'b10, code[11:6]});
                     keep_byte({2'b10, code[5:0]});
                  end
                  esc_mode = ESC_NONE;
                  hex_n = 0;
                  hex_acc = '0;
               end else begin
                  digit_hold[hex_n] = b;
                  hex_acc = {hex_acc[11:0], nib[3:0]};
                  hex_n++;
               end
            end
            default: plain_char(b);
         endcase
      end
      if (it.end_of_string) begin
         if (esc_mode == ESC_HEX) flush_hex();
         esc_mode = ESC_NONE;
         r = '0;
         r.string_done = 1'b1;
         r.out_length = kept;
         r.overflow = dropped;
         step_out.push_back(r);
         kept = '0;
         dropped = 1'b0;
         stopped = 1'b0;
         hex_n = 0;
         hex_acc = '0;
      end
      if (step_out.size() > 0) begin
         last = step_out.size() - 1;
         step_out[last].run_last = 1'b1;
      end
      foreach (step_out[i]) awaited_out.push_back(step_out[i]);
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) return 8'h30 + {4'd0, n};
      return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + {4'd0, n} - 8'd10;
   endfunction

   // One string of random tokens: printable bytes and well-formed escapes, with some broken ones and noise
   task automatic queue_random_string(input int n_tok, inout int added);
      logic [7:0]  text [$];
      logic [15:0] code;
      int          kind;
      int          k;
      for (int t = 0; t < n_tok; t++) begin
         kind = $urandom_range(0, 99);
         if (kind < 33) begin
            text.push_back(8'($urandom_range(8'h20, 8'h7E)));
         end else if (kind < 52) begin
            text.push_back(jsu_pkg::CHR_BSLASH);
            text.push_back(SIMPLE_ESC[$urandom_range(0, 7)]);
         end else if (kind < 74) begin
            case ($urandom_range(0, 3))
               0: code = 16'($urandom_range(16'h0000, 16'h007F));
               1: code = 16'($urandom_range(16'h0080, 16'h07FF));
               2: code = 16'($urandom_range(16'h0800, 16'hFFFF));
               default: code = CODE_EDGES[$urandom_range(0, 5)];
            endcase
            text.push_back(jsu_pkg::CHR_BSLASH);
            text.push_back(jsu_pkg::CHR_U);
            for (int i = 3; i >= 0; i--) text.push_back(hex_char(code[i*4 +: 4]));
         end else if (kind < 82) begin
            // \u broken by a non-hex byte
            text.push_back(jsu_pkg::CHR_BSLASH);
            text.push_back(jsu_pkg::CHR_U);
            k = $urandom_range(0, 3);
            for (int i = 0; i < k; i++) text.push_back(hex_char(4'($urandom_range(0, 15))));
            text.push_back($urandom_range(0, 3) == 0 ? jsu_pkg::CHR_BSLASH
                                                     : 8'($urandom_range(8'h67, 8'hFF)));
         end else if (kind < 88) begin
            text.push_back(jsu_pkg::CHR_BSLASH);
            text.push_back(8'($urandom_range(0, 255)));
         end else if (kind < 96) begin
            text.push_back(8'($urandom_range(0, 255)));
         end else begin
            text.push_back(jsu_pkg::CHR_NUL);
         end
      end
      case ($urandom_range(0, 9))
         0: text.push_back(jsu_pkg::CHR_BSLASH);
         1: begin
            text.push_back(jsu_pkg::CHR_BSLASH);
            text.push_back(jsu_pkg::CHR_U);
            k = $urandom_range(0, 3);
            for (int i = 0; i < k; i++) text.push_back(hex_char(4'($urandom_range(0, 15))));
         end
         default: ;
      endcase
      foreach (text[i])
         pending_in.push_back(jsu_pkg::req_type'{in_byte: text[i],
                                                 end_of_string: (i == text.size() - 1)});
      added += text.size();
   endtask

   // wait until every transaction is in and out, then let the back end run dry
   task automatic settle_idle();
      while (pending_in.size() != 0 || req_push || awaited_out.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic note_mismatch(input string msg);
      n_errors++;
      if (n_errors <= 10) $display("%s", msg);
   endtask

   always @(posedge clock) begin : driver
      bit held;
      int gap_left;
      if (csr_we) capacity = csr_wdata;
      if (reset) begin
         req_push <= 1'b0;
         gap_left = 0;
      end else begin
         held = req_push && req_full;
         if (req_push && !req_full) begin
            unescape_byte(req_data);
            n_items++;
            gap_left = steady ? 0 : $urandom_range(0, 5);
         end
         if (!held) begin
            if (gap_left > 0) begin
               gap_left--;
               req_push <= 1'b0;
            end else if (pending_in.size() != 0) begin
               req_data <= pending_in.pop_front();
               req_push <= 1'b1;
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      jsu_pkg::rsp_type want;
      jsu_pkg::rsp_type got;
      int               pop_wait;
      if (reset) begin
         rsp_pop <= 1'b0;
         pop_wait = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            got = rsp_data;
            n_results++;
            if (got.string_done) n_strings++;
            if (got.string_done && got.overflow) n_overflowed++;
            if (awaited_out.size() == 0) begin
               note_mismatch($sformatf({"unexpected result: byte %h valid %b last %b",
                                        " done %b len %0d ovf %b"},
                  got.out_byte, got.byte_valid, got.run_last, got.string_done,
                  got.out_length, got.overflow));
            end else begin
               want = awaited_out.pop_front();
               if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
                   got.run_last !== want.run_last || got.string_done !== want.string_done ||
                   got.out_length !== want.out_length || got.overflow !== want.overflow)
                  note_mismatch($sformatf(
                     {"mismatch at result %0d: byte %h/%h valid %b/%b last %b/%b",
                      " done %b/%b len %0d/%0d ovf %b/%b (exp/got)"},
                     n_results, want.out_byte, got.out_byte, want.byte_valid, got.byte_valid,
                     want.run_last, got.run_last, want.string_done, got.string_done,
                     want.out_length, got.out_length, want.overflow, got.overflow));
            end
            pop_wait = steady ? 0 : $urandom_range(0, 5);
         end
         if (pop_wait > 0) begin
            pop_wait--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      int quiet;
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                  QUIET_LIMIT, awaited_out.size());
         $display("json_string_unescape_top regression: fail");
         $finish;
      end
   end

   initial begin : stimulus
      int added;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      // directed strings run at the reset capacity
      foreach (DIRECTED[i])
         pending_in.push_back(jsu_pkg::req_type'{in_byte: DIRECTED[i][7:0],
                                                 end_of_string: DIRECTED[i][8]});
      foreach (CAP_STEPS[p]) begin
         settle_idle();
         @(posedge clock);
         csr_we <= 1'b1;
         csr_wdata <= CAP_STEPS[p];
         @(posedge clock);
         csr_we <= 1'b0;
         @(negedge clock);
         steady = (p % 3 == 2);
         added = 0;
         while (added < PHASE_ITEMS) queue_random_string($urandom_range(1, 8), added);
      end
      settle_idle();
      $display("covered %0d input bytes, %0d results in %0d strings (%0d with overflow)",
               n_items, n_results, n_strings, n_overflowed);
      $display("capacities 4096, 1, 65535, 6, 32768, 2, 4096; %0d mismatches", n_errors);
      if (n_errors == 0 && awaited_out.size() == 0) begin
         $display("json_string_unescape_top regression: pass");
      end else begin
         $display("json_string_unescape_top regression: fail");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/jsu_pkg.sv
src/jsu_front.sv
src/jsu_queue.sv
src/jsu_back.sv
src/json_string_unescape_top.sv
sim/json_string_unescape_top_tb.sv
